>>> hdl/dcc_pkg.sv
// shared types, constants and code tables for the dc category bit packer
package dcc_pkg;

  localparam int VAL_BITS      = 10;
  localparam int MAG_BITS      = 9;
  localparam int CAT_BITS      = 4;
  localparam int CODE_BITS     = 16;
  localparam int LEN_BITS      = 5;
  localparam int OUT_WORD_BITS = 32;
  localparam int OUT_CNT_BITS  = 6;

  // -512 is the only value outside the range, it saturates to -511
  localparam logic signed [VAL_BITS-1:0] VAL_NEG_LIMIT = 10'sb10_0000_0000;
  localparam logic signed [VAL_BITS-1:0] VAL_NEG_SAT   = 10'sb10_0000_0001;

  // one classified request handed from front to back
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [LEN_BITS-1:0]  len;
    logic                 eob;
  } dcc_code_t;

  // one result item waiting for the output side
  typedef struct packed {
    logic [OUT_WORD_BITS-1:0] word;
    logic [OUT_CNT_BITS-1:0]  count;
    logic                     last;
  } dcc_res_t;

  // luminance dc prefix codes by category
  function automatic logic [6:0] prefix_code(input logic [CAT_BITS-1:0] cat);
    logic [6:0] c;
    case (cat)
      4'd0:    c = 7'd0;
      4'd1:    c = 7'd2;
      4'd2:    c = 7'd3;
      4'd3:    c = 7'd4;
      4'd4:    c = 7'd5;
      4'd5:    c = 7'd6;
      4'd6:    c = 7'd14;
      4'd7:    c = 7'd30;
      4'd8:    c = 7'd62;
      default: c = 7'd126;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] prefix_len(input logic [CAT_BITS-1:0] cat);
    logic [2:0] l;
    case (cat)
      4'd0:    l = 3'd2;
      4'd1:    l = 3'd3;
      4'd2:    l = 3'd3;
      4'd3:    l = 3'd3;
      4'd4:    l = 3'd3;
      4'd5:    l = 3'd3;
      4'd6:    l = 3'd4;
      4'd7:    l = 3'd5;
      4'd8:    l = 3'd6;
      default: l = 3'd7;
    endcase
    return l;
  endfunction

endpackage

>>> hdl/dcc_front.sv
// front end: saturates and classifies each value and queues its code
module dcc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [9:0]            diff_value,
  input  logic                         end_of_block,
  input  logic                         head_pop,
  output logic                         head_valid,
  output dcc_pkg::dcc_code_t           head
);
  import dcc_pkg::*;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_BITS = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_BITS = $clog2(CQ_DEPTH + 1);

  logic signed [VAL_BITS-1:0] v_sat;
  logic [MAG_BITS-1:0]        mag;
  logic [MAG_BITS-1:0]        amp;
  logic [MAG_BITS-1:0]        amp_mask;
  logic [CAT_BITS-1:0]        cat;
  dcc_code_t                  entry;

  dcc_code_t                  q [CQ_DEPTH];
  logic [CQ_PTR_BITS-1:0]     wptr;
  logic [CQ_PTR_BITS-1:0]     rptr;
  logic [CQ_CNT_BITS-1:0]     cnt;
  logic                       push;

  assign v_sat = (diff_value == VAL_NEG_LIMIT) ? VAL_NEG_SAT : diff_value;
  assign mag   = v_sat[VAL_BITS-1] ? MAG_BITS'(-v_sat) : v_sat[MAG_BITS-1:0];

  // bit length of the magnitude
  always_comb begin
    cat = '0;
    for (int i = 0; i < MAG_BITS; i++) begin
      if (mag[i]) begin
        cat = CAT_BITS'(i + 1);
      end
    end
  end

  // negative values send the ones' complement in the low bits
  assign amp_mask = (MAG_BITS'(1) << cat) - MAG_BITS'(1);
  assign amp      = (v_sat[VAL_BITS-1] ? ~mag : mag) & amp_mask;

  assign entry.code = (CODE_BITS'(prefix_code(cat)) << cat) | CODE_BITS'(amp);
  assign entry.len  = LEN_BITS'(prefix_len(cat)) + LEN_BITS'(cat);
  assign entry.eob  = end_of_block;

  assign in_ready   = (cnt != CQ_CNT_BITS'(CQ_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt != '0);
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + CQ_PTR_BITS'(1);
      end
      if (head_pop) begin
        rptr <= rptr + CQ_PTR_BITS'(1);
      end
      cnt <= cnt + CQ_CNT_BITS'(push) - CQ_CNT_BITS'(head_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= entry;
    end
  end

endmodule

>>> hdl/dcc_back.sv
// back end: bit accumulator, word split and flush, result queue
module dcc_back #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  dcc_pkg::dcc_code_t   head,
  output logic                 head_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcc_pkg::dcc_res_t    out_res
);
  import dcc_pkg::*;

  localparam int FW = $clog2(WORD_BITS);
  localparam int SW = FW + 1;
  localparam int EW = WORD_BITS + CODE_BITS;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  logic [WORD_BITS-1:0]   acc;
  logic [FW-1:0]          fill;

  logic [SW-1:0]          sum;
  logic                   full;
  logic [LEN_BITS-1:0]    rem_len;
  logic [EW-1:0]          ext;
  logic [WORD_BITS-1:0]   full_word;
  logic [CODE_BITS-1:0]   rem_bits;
  logic [WORD_BITS-1:0]   acc_mid;
  logic [FW-1:0]          fill_mid;
  logic                   flush;
  dcc_res_t               res_a;
  dcc_res_t               res_b;

  dcc_res_t               oq [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wptr;
  logic [OQ_PTR_BITS-1:0] wptr_b;
  logic [OQ_PTR_BITS-1:0] rptr;
  logic [OQ_CNT_BITS-1:0] cnt;
  logic                   push_a;
  logic                   push_b;
  logic [1:0]             n_push;
  logic                   out_pop;

  assign sum  = SW'(fill) + SW'(head.len);
  assign full = (sum >= SW'(WORD_BITS));
  assign rem_len = LEN_BITS'(sum - SW'(WORD_BITS));

  // pending bits followed by the new code, right-aligned
  assign ext       = (EW'(acc) << head.len) | EW'(head.code);
  assign full_word = WORD_BITS'(ext >> rem_len);
  assign rem_bits  = head.code & ((CODE_BITS'(1) << rem_len) - CODE_BITS'(1));

  assign acc_mid  = full ? WORD_BITS'(rem_bits) : WORD_BITS'(ext);
  assign fill_mid = full ? FW'(rem_len) : FW'(sum);
  assign flush    = head.eob && (fill_mid != '0);

  always_comb begin
    res_a.word  = full ? OUT_WORD_BITS'(full_word) : OUT_WORD_BITS'(acc_mid);
    res_a.count = full ? OUT_CNT_BITS'(WORD_BITS) : OUT_CNT_BITS'(fill_mid);
    res_a.last  = !(full && flush);
    res_b.word  = OUT_WORD_BITS'(acc_mid);
    res_b.count = OUT_CNT_BITS'(fill_mid);
    res_b.last  = 1'b1;
  end

  // take a request only when two result slots are free
  assign head_pop = head_valid && (cnt <= OQ_CNT_BITS'(OQ_DEPTH - 2));
  assign push_a   = head_pop && (full || flush);
  assign push_b   = head_pop && full && flush;
  assign n_push   = {1'b0, push_a} + {1'b0, push_b};
  assign wptr_b   = wptr + OQ_PTR_BITS'(1);

  assign out_valid = (cnt != '0);
  assign out_res   = oq[rptr];
  assign out_pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      fill <= '0;
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (head_pop) begin
        acc  <= flush ? '0 : acc_mid;
        fill <= flush ? '0 : fill_mid;
      end
      wptr <= wptr + OQ_PTR_BITS'(n_push);
      if (out_pop) begin
        rptr <= rptr + OQ_PTR_BITS'(1);
      end
      cnt <= cnt + OQ_CNT_BITS'(n_push) - OQ_CNT_BITS'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      oq[wptr] <= res_a;
    end
    if (push_b) begin
      oq[wptr_b] <= res_b;
    end
  end

endmodule

>>> hdl/dc_category_huffman_bit_packer.sv
// an item's code is registered in the front request queue, then its results in the result queue
// throughput: one item per cycle while the result queue has two free slots; an item that yields
// two results (word plus flush) puts both into the four-entry result queue, drained in order
// the front holds two classified requests, so either side may stall on its own
// rst (synchronous, active high) empties both queues and clears the bit accumulator
module dc_category_huffman_bit_packer #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // diff_value [9:0], zero [15:10]
  input  logic        s_tlast,   // end_of_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // packed_word [31:0], bit_count [37:32], zero [39:38]
  output logic        m_tlast    // last
);
  import dcc_pkg::*;

  logic      cq_valid;
  logic      cq_pop;
  dcc_code_t cq_head;
  dcc_res_t  res;

  dcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .diff_value   (s_tdata[VAL_BITS-1:0]),
    .end_of_block (s_tlast),
    .head_pop     (cq_pop),
    .head_valid   (cq_valid),
    .head         (cq_head)
  );

  dcc_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (cq_valid),
    .head       (cq_head),
    .head_pop   (cq_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (res)
  );

  assign m_tdata = {2'b00, res.count, res.word};
  assign m_tlast = res.last;

`ifndef SYNTHESIS
  a_pop_needs_request: assert property (@(posedge clk) disable iff (rst)
    cq_pop |-> cq_valid)
    else $error("back end took a request from an empty queue");

  a_stall_means_queued: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> cq_valid)
    else $error("input stalled while the request queue is empty");

  a_valid_drops_on_take: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(m_tvalid)) |-> $past(m_tready))
    else $error("result withdrawn without being taken");
`endif

endmodule
